[hdl/spr_pkg.sv]
// Shared types and codes for the shortest path relaxation unit.
package spr_pkg;

    // Kind of an input beat, carried on s_tuser.
    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_SOLVE = 1'b1
    } cmd_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROW,
        ST_RD,
        ST_EVAL,
        ST_OUT_RD,
        ST_OUT_LOAD
    } state_t;

    localparam int DIST_BITS = 32;
    localparam int NODE_BITS = 4;
    localparam int NODE_LIMIT = 16;

    // Outcome of one edge relaxation.
    typedef struct packed {
        logic                        update;
        logic signed [DIST_BITS-1:0] cand;
    } relax_t;

endpackage

[hdl/spr_relax.sv]
// Shared relaxation unit: saturating distance plus weight, compared against the target.
module spr_relax
    import spr_pkg::*;
#(
    parameter int WEIGHT_BITS = 16
) (
    input  logic signed [DIST_BITS-1:0]   dist_j,
    input  logic signed [WEIGHT_BITS-1:0] weight,
    input  logic signed [DIST_BITS-1:0]   dist_k,
    input  logic                          reached_k,
    output relax_t                        relax
);

    logic signed [DIST_BITS:0]   sum;
    logic signed [DIST_BITS-1:0] cand;

    always_comb begin
        sum = (DIST_BITS+1)'(dist_j) + (DIST_BITS+1)'(weight);
        // The sum needs one extra bit at most; a disagreement of the top two bits is an overflow.
        if (sum[DIST_BITS] != sum[DIST_BITS-1]) begin
            cand = sum[DIST_BITS] ? {1'b1, {(DIST_BITS-1){1'b0}}}
                                  : {1'b0, {(DIST_BITS-1){1'b1}}};
        end else begin
            cand = sum[DIST_BITS-1:0];
        end
        relax.cand   = cand;
        relax.update = (weight != '0) && (!reached_k || (cand < dist_k));
    end

endmodule

[hdl/shortest_path_relaxation_unit.sv]
// Top level of the shortest path relaxation unit: sequencer, weight and distance stores.
//
// Single-source shortest paths over a weighted adjacency matrix, in the Bellman-Ford manner.
// An input beat with s_tuser low writes one signed weight into the matrix at (row, col); a
// weight of zero means there is no edge, and writes outside the matrix are dropped. A beat with
// s_tuser high starts a solve from the given source over the first n nodes, where n is the
// configured node count held to the range 2 to the smaller of MAX_NODES and 16. The solve runs
// n - 1 passes over every ordered node pair in row-major order, relaxing each target through
// the edge from an origin that is already reached, and then sends n result beats, one per node
// in node order, with the distance (saturated to 32 bits, zero where unreached), the reachable
// flag on m_tuser and m_tlast on the final node. Negative cycles are not detected. After reset
// the weight matrix is zeroed by a clearing pass over all MAX_NODES * MAX_NODES entries, during
// which no input beat is taken; configuration writes are taken at any time. A solve is carried
// out by one shared adder and comparator under a small sequencer that reads one weight and one
// distance per pair from registered-output stores; the row of an origin that is not yet reached
// is passed over without reading its pairs. The next input beat is taken once the final result
// beat has been loaded into the output register.
module shortest_path_relaxation_unit
    import spr_pkg::*;
#(
    parameter int MAX_NODES   = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: node count in use.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    // Input beats.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // row[3:0], col[7:4], weight[23:8], source[27:24], zero pad
    input  logic        s_tuser,   // cmd: 0 write weight, 1 start solve
    // Result beats.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // node[3:0], dist_res[35:4], zero pad
    output logic        m_tuser,   // reachable
    output logic        m_tlast    // final node of a solve
);

    localparam int NLIM  = (MAX_NODES < NODE_LIMIT) ? MAX_NODES : NODE_LIMIT;
    localparam int KW    = $clog2(NLIM);
    localparam int DEPTH = MAX_NODES * MAX_NODES;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);
    localparam logic [4:0]    NLIM5    = 5'(NLIM);

    // Input field views.
    logic [NODE_BITS-1:0]    s_row;
    logic [NODE_BITS-1:0]    s_col;
    logic signed [15:0]      s_weight;
    logic [NODE_BITS-1:0]    s_source;
    cmd_t                    s_cmd;

    assign s_row    = s_tdata[3:0];
    assign s_col    = s_tdata[7:4];
    assign s_weight = s_tdata[23:8];
    assign s_source = s_tdata[27:24];
    assign s_cmd    = cmd_t'(s_tuser);

    // Control registers.
    state_t           state_reg, state_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [KW-1:0]    j_reg, j_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [KW-1:0]    pass_reg, pass_next;
    logic [KW-1:0]    n_m1_reg, n_m1_next;
    logic [NLIM-1:0]  reached_reg, reached_next;
    logic [4:0]       nodes_cfg_reg;
    logic             m_valid_reg, m_valid_next;

    // Payload registers.
    logic signed [DIST_BITS-1:0] dist_j_reg, dist_j_next;
    logic [NODE_BITS-1:0]        node_out_reg, node_out_next;
    logic signed [DIST_BITS-1:0] dist_out_reg, dist_out_next;
    logic                        reach_out_reg, reach_out_next;
    logic                        last_out_reg, last_out_next;

    // Store ports.
    logic                          wmem_we;
    logic [AW-1:0]                 wmem_waddr;
    logic signed [WEIGHT_BITS-1:0] wmem_wdata;
    logic [AW-1:0]                 wmem_raddr;
    logic signed [WEIGHT_BITS-1:0] wmem_rd_reg;
    logic                          dmem_we;
    logic [KW-1:0]                 dmem_waddr;
    logic signed [DIST_BITS-1:0]   dmem_wdata;
    logic [KW-1:0]                 dmem_raddr;
    logic signed [DIST_BITS-1:0]   dmem_rd_reg;

    logic signed [WEIGHT_BITS-1:0] weight_mem [DEPTH];
    logic signed [DIST_BITS-1:0]   dist_mem [NLIM];

    relax_t           relax;
    logic [4:0]       n_sel;
    logic             src_ok;
    logic             row_ok;
    logic             out_free;
    logic             k_last;
    logic             j_last;
    logic             pass_last;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, dist_out_reg, node_out_reg};
    assign m_tuser  = reach_out_reg;
    assign m_tlast  = last_out_reg;

    spr_relax #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_relax (
        .dist_j    (dist_j_reg),
        .weight    (wmem_rd_reg),
        .dist_k    (dmem_rd_reg),
        .reached_k (reached_reg[k_reg]),
        .relax     (relax)
    );

    // Node count held to its legal range when a solve starts.
    always_comb begin
        if (nodes_cfg_reg < 5'd2) begin
            n_sel = 5'd2;
        end else if (nodes_cfg_reg > NLIM5) begin
            n_sel = NLIM5;
        end else begin
            n_sel = nodes_cfg_reg;
        end
        src_ok = ({1'b0, s_source} < n_sel);
        row_ok = (int'(s_row) < MAX_NODES) && (int'(s_col) < MAX_NODES);
    end

    assign out_free  = !m_valid_reg || m_tready;
    assign k_last    = (k_reg == n_m1_reg);
    assign j_last    = (j_reg == n_m1_reg);
    assign pass_last = (pass_reg == KW'(n_m1_reg - 1'b1));

    // Sequencer: next state, counters and store controls.
    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        pass_next      = pass_reg;
        n_m1_next      = n_m1_reg;
        reached_next   = reached_reg;
        dist_j_next    = dist_j_reg;
        node_out_next  = node_out_reg;
        dist_out_next  = dist_out_reg;
        reach_out_next = reach_out_reg;
        last_out_next  = last_out_reg;
        m_valid_next   = m_valid_reg && !m_tready;

        wmem_we    = 1'b0;
        wmem_waddr = AW'(s_row) * AW'(MAX_NODES) + AW'(s_col);
        wmem_wdata = WEIGHT_BITS'(s_weight);
        wmem_raddr = AW'(j_reg) * AW'(MAX_NODES) + AW'(k_reg);
        dmem_we    = 1'b0;
        dmem_waddr = k_reg;
        dmem_wdata = relax.cand;
        dmem_raddr = k_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                wmem_we    = 1'b1;
                wmem_waddr = clr_reg;
                wmem_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (s_cmd)
                        CMD_WRITE: begin
                            wmem_we = row_ok;
                        end
                        CMD_SOLVE: begin
                            n_m1_next    = KW'(n_sel - 5'd1);
                            reached_next = '0;
                            if (src_ok) begin
                                reached_next[KW'(s_source)] = 1'b1;
                            end
                            // The source starts at distance zero; other entries are only
                            // used once they have been reached and written.
                            dmem_we    = src_ok;
                            dmem_waddr = KW'(s_source);
                            dmem_wdata = '0;
                            j_next     = '0;
                            k_next     = '0;
                            pass_next  = '0;
                            state_next = ST_ROW;
                        end
                        default: ;
                    endcase
                end
            end

            ST_ROW: begin
                // An origin not yet reached relaxes nothing, so its whole row is passed over.
                dmem_raddr = j_reg;
                if (reached_reg[j_reg]) begin
                    state_next = ST_RD;
                end else if (j_last) begin
                    j_next = '0;
                    if (pass_last) begin
                        state_next = ST_OUT_RD;
                    end else begin
                        pass_next = pass_reg + 1'b1;
                    end
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end

            ST_RD: begin
                // On the first pair of a row the distance store still holds the origin's distance.
                if (k_reg == '0) begin
                    dist_j_next = dmem_rd_reg;
                end
                state_next = ST_EVAL;
            end

            ST_EVAL: begin
                if (relax.update) begin
                    dmem_we             = 1'b1;
                    reached_next[k_reg] = 1'b1;
                    // A self loop changes the origin's own distance for the rest of the row.
                    if (k_reg == j_reg) begin
                        dist_j_next = relax.cand;
                    end
                end
                if (k_last) begin
                    k_next     = '0;
                    state_next = ST_ROW;
                    if (j_last) begin
                        j_next = '0;
                        if (pass_last) begin
                            state_next = ST_OUT_RD;
                        end else begin
                            pass_next = pass_reg + 1'b1;
                        end
                    end else begin
                        j_next = j_reg + 1'b1;
                    end
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_RD;
                end
            end

            ST_OUT_RD: begin
                state_next = ST_OUT_LOAD;
            end

            ST_OUT_LOAD: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    node_out_next  = NODE_BITS'(k_reg);
                    reach_out_next = reached_reg[k_reg];
                    dist_out_next  = reached_reg[k_reg] ? dmem_rd_reg : '0;
                    last_out_next  = k_last;
                    if (k_last) begin
                        k_next     = '0;
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_OUT_RD;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            pass_reg      <= '0;
            n_m1_reg      <= KW'(NLIM - 1);
            reached_reg   <= '0;
            nodes_cfg_reg <= 5'd16;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            pass_reg    <= pass_next;
            n_m1_reg    <= n_m1_next;
            reached_reg <= reached_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                nodes_cfg_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        dist_j_reg    <= dist_j_next;
        node_out_reg  <= node_out_next;
        dist_out_reg  <= dist_out_next;
        reach_out_reg <= reach_out_next;
        last_out_reg  <= last_out_next;
    end

    // Weight matrix store.
    always_ff @(posedge aclk) begin
        if (wmem_we) begin
            weight_mem[wmem_waddr] <= wmem_wdata;
        end
        wmem_rd_reg <= weight_mem[wmem_raddr];
    end

    // Distance store.
    always_ff @(posedge aclk) begin
        if (dmem_we) begin
            dist_mem[dmem_waddr] <= dmem_wdata;
        end
        dmem_rd_reg <= dist_mem[dmem_raddr];
    end

    // The matrix is not ready for use straight after reset.
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input accepted before the weight clearing pass");

    // A solve starts with at most the source marked as reached.
    a_solve_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> $countones(reached_reg) <= 1)
        else $error("reached flags not cleared at solve start");

    // A relaxed target is reached from then on.
    a_relax_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EVAL && relax.update |=> reached_reg[$past(k_reg)])
        else $error("relaxed target not marked as reached");

    // The pair counters stay within the nodes in use.
    a_counter_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_CLEAR |-> k_reg <= n_m1_reg && j_reg <= n_m1_reg)
        else $error("node counter beyond the nodes in use");

endmodule

[verif/shortest_path_relaxation_unit_test.sv]
// Self-checking testbench for the shortest path relaxation unit.
module shortest_path_relaxation_unit_test;
    import spr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Generous ceiling on the run: several times a run in which every beat is a full
    // sixteen-node solve with a stalling result side.
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam longint DIST_MAX = 64'sd2147483647;
    localparam longint DIST_MIN = -64'sd2147483648;
    // Directed beats plus the random beats that follow them.
    localparam int BEAT_TARGET = 157;
    // How long the result side holds off when asked to, in cycles.
    localparam int HOLD_CYCLES = 600;
    // Cycles left for a weight write to settle before the register is touched.
    localparam int WRITE_SETTLE = 4;

    // One result beat: the distance report for one node.
    typedef struct {
        logic [3:0]         node;
        logic signed [31:0] dist_res;
        logic               reachable;
        logic               last;
    } node_result_t;

    // Keeps a private copy of the weight matrix and the node count, works out the
    // distance report of every accepted solve beat and checks the result beats against it.
    class route_scoreboard;
        logic signed [15:0] wt_mat [16][16];
        logic [4:0]         node_cfg;
        node_result_t       report_q [$];
        int                 errors;

        function new();
            foreach (wt_mat[j, k]) wt_mat[j][k] = '0;
            node_cfg = 5'd16;
            errors   = 0;
        endfunction

        function void set_node_count(logic [4:0] value);
            node_cfg = value;
        endfunction

        function int pending();
            return report_q.size();
        endfunction

        // Called for every accepted input beat.
        function void note_beat(cmd_t cmd, logic [3:0] row, logic [3:0] col,
                                logic signed [15:0] wt, logic [3:0] src);
            int unsigned        n;
            logic signed [31:0] span [16];
            bit                 reached [16];
            longint             sum;
            logic signed [31:0] cand;
            node_result_t       res;
            if (cmd == CMD_WRITE) begin
                wt_mat[row][col] = wt;
                return;
            end
            n = (node_cfg < 2) ? 2 : ((node_cfg > 16) ? 16 : node_cfg);
            foreach (span[k]) begin
                span[k]    = '0;
                reached[k] = 1'b0;
            end
            if (src < n) reached[src] = 1'b1;
            // n - 1 passes over every ordered pair; only reached origins relax their targets.
            for (int pass = 0; pass + 1 < n; pass++) begin
                for (int j = 0; j < n; j++) begin
                    for (int k = 0; k < n; k++) begin
                        if (wt_mat[j][k] != 0 && reached[j]) begin
                            sum = longint'(span[j]) + longint'(wt_mat[j][k]);
                            if (sum > DIST_MAX) cand = 32'sh7fff_ffff;
                            else if (sum < DIST_MIN) cand = 32'sh8000_0000;
                            else cand = sum[31:0];
                            if (!reached[k] || cand < span[k]) begin
                                span[k]    = cand;
                                reached[k] = 1'b1;
                            end
                        end
                    end
                end
            end
            for (int k = 0; k < n; k++) begin
                res.node      = k[3:0];
                res.dist_res  = reached[k] ? span[k] : '0;
                res.reachable = reached[k];
                res.last      = (k + 1 == n);
                report_q.push_back(res);
            end
        endfunction

        // Called for every accepted result beat.
        function void check_result(node_result_t got);
            node_result_t want;
            if (report_q.size() == 0) begin
                $display("%0t: result beat with nothing expected: node %0d dist %0d reach %0b",
                         $time, got.node, got.dist_res, got.reachable);
                errors++;
                return;
            end
            want = report_q.pop_front();
            if (got.node !== want.node) begin
                $display("%0t: node expected %0d got %0d", $time, want.node, got.node);
                errors++;
            end
            if (got.dist_res !== want.dist_res) begin
                $display("%0t: node %0d distance expected %0d got %0d",
                         $time, want.node, want.dist_res, got.dist_res);
                errors++;
            end
            if (got.reachable !== want.reachable) begin
                $display("%0t: node %0d reachable expected %0b got %0b",
                         $time, want.node, want.reachable, got.reachable);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: node %0d last expected %0b got %0b",
                         $time, want.node, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;   // row[3:0], col[7:4], weight[23:8], source[27:24], zero pad
    logic        s_tuser   = 1'b0; // cmd: write weight or start solve
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;          // node[3:0], dist_res[35:4], zero pad
    logic        m_tuser;          // reachable
    logic        m_tlast;          // final node of a solve

    route_scoreboard sb = new();

    // Stimulus controls shared with the result side.
    bit tx_idle_on  = 1'b1;
    bit rx_idle_on  = 1'b1;
    int hold_asks   = 0;
    int beats_sent  = 0;
    int cycle_count = 0;

    shortest_path_relaxation_unit #(
        .MAX_NODES   (16),
        .WEIGHT_BITS (16)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog: a hung handshake or a result that never comes ends the run here.
    initial begin : watchdog
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("shortest_path_relaxation_unit_test: errors");
                $finish;
            end
        end
    end

    // Result side. Every accepted beat is checked; tready idles at random, and on request
    // it is held low for a long stretch so that the unit backs up and stalls its input.
    initial begin : result_sink
        int           hold_left   = 0;
        int           hold_served = 0;
        node_result_t got;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got.node      = m_tdata[3:0];
                got.dist_res  = m_tdata[35:4];
                got.reachable = m_tuser;
                got.last      = m_tlast;
                sb.check_result(got);
            end
            if (hold_asks != hold_served) begin
                hold_served = hold_asks;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(rx_idle_on && $urandom_range(0, 99) < 27);
            end
        end
    end

    // Mostly modest positive weights so that paths form, with negative, zero and
    // full-range values mixed in.
    function automatic logic [15:0] pick_weight();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 16'($urandom_range(1, 40));
        if (r < 85) return -16'($urandom_range(1, 5));
        if (r < 92) return '0;
        return 16'($urandom);
    endfunction

    // Offers one input beat and returns at the edge where it is taken. The valid is left
    // high, so back-to-back beats do not drop it between them unless input idling is on.
    task automatic send_beat(input cmd_t cmd, input logic [3:0] row, input logic [3:0] col,
                             input logic [15:0] wt, input logic [3:0] src);
        if (tx_idle_on) begin
            while ($urandom_range(0, 99) < 27) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0000, src, wt, col, row};
        do @(posedge aclk); while (!s_tready);
        sb.note_beat(cmd, row, col, wt, src);
        beats_sent++;
    endtask

    // The fields that a beat's kind does not use still carry random bits.
    task automatic write_weight(input logic [3:0] row, input logic [3:0] col,
                                input logic [15:0] wt);
        send_beat(CMD_WRITE, row, col, wt, 4'($urandom));
    endtask

    task automatic solve_from(input logic [3:0] src);
        send_beat(CMD_SOLVE, 4'($urandom), 4'($urandom), 16'($urandom), src);
    endtask

    // Stops offering beats and waits until every expected result beat has arrived, then
    // leaves a trailing weight write time to land.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (WRITE_SETTLE) @(posedge aclk);
    endtask

    // Writes the node count; only ever called while no solve is in progress.
    task automatic set_nodes(input logic [4:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_node_count(value);
    endtask

    initial begin : stimulus
        int          phase = 0;
        logic [4:0]  nodes_val;
        int unsigned n_eff;
        int unsigned n_writes;
        int unsigned n_solves;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        // The clearing pass after reset holds s_tready low; the first beat simply waits.

        // Four nodes: the chain 0 -> 1 -> 2 -> 3 uses both weight extremes, node 0 carries a
        // negative self loop, and a few edges sit outside the nodes in use.
        set_nodes(5'd4);
        write_weight(4'd0, 4'd1, 16'sh7fff);
        write_weight(4'd1, 4'd2, 16'sh8000);
        write_weight(4'd2, 4'd3, 16'sd1);
        write_weight(4'd0, 4'd0, -16'sd3);
        write_weight(4'd15, 4'd15, 16'hffff);
        write_weight(4'd15, 4'd0, 16'sd7);
        write_weight(4'd3, 4'd15, 16'sd100);
        // The result side holds off while further solves are offered behind this one,
        // among them a source beyond the node count and one that reaches few nodes.
        hold_asks++;
        solve_from(4'd0);
        solve_from(4'd15);
        solve_from(4'd2);
        settle();

        // A node count of zero is held at two nodes; node 1 reaches nothing, then an edge
        // back to node 0 is added.
        set_nodes(5'd0);
        solve_from(4'd1);
        write_weight(4'd1, 4'd0, -16'sd7);
        solve_from(4'd1);
        solve_from(4'd0);
        settle();

        // The largest count is held at sixteen; the self loop is removed by a zero weight.
        set_nodes(5'd31);
        write_weight(4'd0, 4'd0, 16'h0000);
        solve_from(4'd0);
        solve_from(4'd15);
        settle();

        // Random phases: a node count, a burst of edge writes, then one or two solves.
        // The first few phases pin the count to its extremes; a run of phases in the middle
        // has no idling on either side.
        while (beats_sent < BEAT_TARGET) begin
            case (phase)
                0: nodes_val = 5'd1;
                1: nodes_val = 5'd16;
                2: nodes_val = 5'd2;
                default: begin
                    if ($urandom_range(0, 9) == 0) nodes_val = 5'($urandom_range(0, 31));
                    else nodes_val = 5'($urandom_range(2, 6));
                end
            endcase
            tx_idle_on = !(phase >= 4 && phase <= 7);
            rx_idle_on = tx_idle_on;
            set_nodes(nodes_val);
            n_eff = (nodes_val < 2) ? 2 : ((nodes_val > 16) ? 16 : nodes_val);

            n_writes = $urandom_range(1, 10);
            repeat (n_writes) begin
                // Mostly edges among the nodes in use, now and then anywhere in the matrix.
                if ($urandom_range(0, 99) < 85)
                    write_weight(4'($urandom_range(0, n_eff - 1)),
                                 4'($urandom_range(0, n_eff - 1)), pick_weight());
                else
                    write_weight(4'($urandom), 4'($urandom), pick_weight());
            end

            n_solves = $urandom_range(1, 2);
            repeat (n_solves) begin
                if ($urandom_range(0, 9) != 0) solve_from(4'($urandom_range(0, n_eff - 1)));
                else solve_from(4'($urandom));
            end
            settle();
            phase++;
        end

        // Anything arriving late is caught by the result side during this wait.
        repeat (40) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("shortest_path_relaxation_unit_test: clean");
        end else begin
            $display("shortest_path_relaxation_unit_test: errors");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/spr_pkg.sv
hdl/spr_relax.sv
hdl/shortest_path_relaxation_unit.sv
verif/shortest_path_relaxation_unit_test.sv
